// File: design/btpc_pkg.sv
// Package for the barometric compensation block: constants, types and helpers.
package btpc_pkg;

    localparam int RAW_W   = 20;
    localparam int DIV_W   = 64;
    localparam int CENTI_W = 25;
    localparam int CFG_IDX_W = 3;

    localparam logic [20:0] RAW_FULL_SCALE = 21'd1048576;
    localparam logic [33:0] T_FINE_OFFSET  = 34'd128000;
    localparam logic [11:0] PRESS_SCALE    = 12'd3125;
    localparam logic [31:0] T_ROUND        = 32'd128;
    localparam logic [63:0] P1_BASE        = 64'h0000_8000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMP_COEFF  = 3'd0,
        CFG_PRESS_LOW   = 3'd1,
        CFG_PRESS_MID   = 3'd2,
        CFG_PRESS_NINE  = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CENTI_W-1:0] centi;
        logic [31:0]        fine;
        logic               dz;
    } t_side;

    function automatic logic signed [63:0] sext16(input logic [15:0] w);
        sext16 = {{48{w[15]}}, w};
    endfunction

endpackage

// File: design/btpc_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, with sideband.
module btpc_div import btpc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    input  t_side            i_side,
    output logic             o_valid,
    output logic [DIV_W-1:0] o_quotient,
    output t_side            o_side
);

    logic [DIV_W-1:0] r_rem  [0:DIV_W];
    logic [DIV_W-1:0] r_q    [0:DIV_W];
    logic [DIV_W-1:0] r_d    [0:DIV_W];
    logic             r_neg  [0:DIV_W];
    t_side            r_side [0:DIV_W];
    logic             r_v    [0:DIV_W];
    logic [DIV_W-1:0] r_quot;
    t_side            r_oside;
    logic             r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
        if (i_en) begin
            r_rem[0]  <= '0;
            r_q[0]    <= i_dividend[DIV_W-1] ? (~i_dividend + 1'b1) : i_dividend;
            r_d[0]    <= i_divisor[DIV_W-1] ? (~i_divisor + 1'b1) : i_divisor;
            r_neg[0]  <= i_dividend[DIV_W-1] ^ i_divisor[DIV_W-1];
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [DIV_W:0] trial;
        logic [DIV_W:0] diff;
        logic           take;
        assign trial = {r_rem[k], r_q[k][DIV_W-1]};
        assign diff  = trial - {1'b0, r_d[k]};
        assign take  = trial >= {1'b0, r_d[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
            if (i_en) begin
                r_rem[k+1]  <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
                r_q[k+1]    <= {r_q[k][DIV_W-2:0], take};
                r_d[k+1]    <= r_d[k];
                r_neg[k+1]  <= r_neg[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[DIV_W];
        end
        if (i_en) begin
            r_quot  <= r_neg[DIV_W] ? (~r_q[DIV_W] + 1'b1) : r_q[DIV_W];
            r_oside <= r_side[DIV_W];
        end
    end

    assign o_valid    = r_ov;
    assign o_quotient = r_quot;
    assign o_side     = r_oside;

endmodule

// File: design/baro_temp_pressure_compensation.sv
// Barometric temperature and pressure compensation, fixed-point pipeline.
// Throughput: one item per cycle while no result waits under stall;
// the 64-stage bit-per-stage divider sets the depth.
// Whole pipeline advances together; it holds only when a result waits under stall.
// Synchronous active-low reset clears valid bits and calibration registers.
module baro_temp_pressure_compensation import btpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [RAW_W-1:0]     i_raw_temperature,
    input  logic [RAW_W-1:0]     i_raw_pressure,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [CENTI_W-1:0] o_temperature_centi,
    output logic signed [31:0]   o_fine_temperature,
    output logic [31:0]          o_pressure_q24_8,
    output logic                 o_divide_by_zero,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    logic [47:0] r_tc;
    logic [63:0] r_pl;
    logic [63:0] r_pm;
    logic [15:0] r_p9;
    logic        r_out_valid;
    logic        en;

    assign en          = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc <= '0;
            r_pl <= '0;
            r_pm <= '0;
            r_p9 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TEMP_COEFF: r_tc <= i_cfg_data[47:0];
                CFG_PRESS_LOW:  r_pl <= i_cfg_data;
                CFG_PRESS_MID:  r_pm <= i_cfg_data;
                CFG_PRESS_NINE: r_p9 <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    logic [15:0]        t1;
    logic signed [31:0] t2, t3;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    assign t1 = r_tc[15:0];
    assign t2 = {{16{r_tc[31]}}, r_tc[31:16]};
    assign t3 = {{16{r_tc[47]}}, r_tc[47:32]};
    assign p1 = {48'b0, r_pl[15:0]};
    assign p2 = sext16(r_pl[31:16]);
    assign p3 = sext16(r_pl[47:32]);
    assign p4 = sext16(r_pl[63:48]);
    assign p5 = sext16(r_pm[15:0]);
    assign p6 = sext16(r_pm[31:16]);
    assign p7 = sext16(r_pm[47:32]);
    assign p8 = sext16(r_pm[63:48]);
    assign p9 = sext16(r_p9);

    // valid bits for stages 1..11
    logic [11:1] r_v;

    logic [RAW_W-1:0]   r1_rt, r_rp [1:10];
    logic signed [31:0] r2_x, r2_d;
    logic signed [31:0] r3_ap, r3_dd;
    logic signed [31:0] r4_a, r4_b;
    logic signed [31:0] r_fine [5:11];
    logic [CENTI_W-1:0] r_centi [6:11];
    logic signed [33:0] r6_v1;
    logic signed [63:0] r7_vv, r7_vp5, r7_vp2;
    logic signed [63:0] r8_v2a, r8_w1a, r8_vp5, r8_vp2;
    logic signed [63:0] r_v2 [9:10];
    logic signed [63:0] r9_w1b, r10_w1c;
    logic signed [63:0] r11_w1, r11_pnum;

    logic signed [33:0] fine34;
    logic signed [31:0] centi_full;
    logic signed [67:0] vv_full;
    logic signed [63:0] prod_5, prod_2;
    logic [20:0]        pdiff;
    assign fine34     = {{2{r_fine[5][31]}}, r_fine[5]} - T_FINE_OFFSET;
    assign centi_full = (r_fine[5] * 32'sd5 + $signed(T_ROUND)) >>> 8;
    assign vv_full    = 68'(r6_v1) * 68'(r6_v1);
    assign prod_5     = 64'(r6_v1) * p5;
    assign prod_2     = 64'(r6_v1) * p2;
    assign pdiff      = RAW_FULL_SCALE - {1'b0, r_rp[10]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[10:1], i_in_valid};
        end
        if (en) begin
            r1_rt    <= i_raw_temperature;
            r_rp[1]  <= i_raw_pressure;
            for (int i = 2; i <= 10; i++) r_rp[i] <= r_rp[i-1];
            r2_x     <= {15'b0, r1_rt[19:3]} - {15'b0, t1, 1'b0};
            r2_d     <= {16'b0, r1_rt[19:4]} - {16'b0, t1};
            r3_ap    <= r2_x * t2;
            r3_dd    <= r2_d * r2_d;
            r4_a     <= r3_ap >>> 11;
            r4_b     <= (r3_dd >>> 12) * t3;
            r_fine[5] <= r4_a + (r4_b >>> 14);
            for (int i = 6; i <= 11; i++) r_fine[i] <= r_fine[i-1];
            r_centi[6] <= centi_full[CENTI_W-1:0];
            for (int i = 7; i <= 11; i++) r_centi[i] <= r_centi[i-1];
            r6_v1    <= fine34;
            r7_vv    <= vv_full[63:0];
            r7_vp5   <= prod_5;
            r7_vp2   <= prod_2;
            r8_v2a   <= r7_vv * p6;
            r8_w1a   <= r7_vv * p3;
            r8_vp5   <= r7_vp5;
            r8_vp2   <= r7_vp2;
            r_v2[9]  <= r8_v2a + (r8_vp5 <<< 17) + (p4 <<< 35);
            r_v2[10] <= r_v2[9];
            r9_w1b   <= (r8_w1a >>> 8) + (r8_vp2 <<< 12);
            r10_w1c  <= (r9_w1b + P1_BASE) * p1;
            r11_w1   <= r10_w1c >>> 33;
            r11_pnum <= ({43'b0, pdiff} <<< 31) - r_v2[10];
        end
    end

    logic               dv_v;
    logic [DIV_W-1:0]   dv_q;
    t_side              dv_side, side_in;
    logic signed [63:0] dividend;
    assign dividend      = r11_pnum * {52'b0, PRESS_SCALE};
    assign side_in.centi = r_centi[11];
    assign side_in.fine  = r_fine[11];
    assign side_in.dz    = (r11_w1 == 64'sd0);

    btpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v[11]),
        .i_dividend (dividend),
        .i_divisor  (r11_w1),
        .i_side     (side_in),
        .o_valid    (dv_v),
        .o_quotient (dv_q),
        .o_side     (dv_side)
    );

    logic [4:1]         r_pv;
    t_side              r_ps [1:4];
    logic signed [63:0] r_pq [1:3];
    logic [63:0]        ra_ll;
    logic [31:0]        ra_hl;
    logic signed [63:0] r_c2 [1:3];
    logic signed [63:0] rb_sq, rc_c1, rd_p;
    logic [31:0]        r_press;
    t_side              r_oside;

    logic signed [63:0] ps, q_s, c2_full, c1_full;
    assign q_s     = dv_q;
    assign ps      = q_s >>> 13;
    assign c2_full = q_s * p8;
    assign c1_full = rb_sq * p9;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv        <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_pv        <= {r_pv[3:1], dv_v};
            r_out_valid <= r_pv[4];
        end
        if (en) begin
            r_ps[1] <= dv_side;
            for (int i = 2; i <= 4; i++) r_ps[i] <= r_ps[i-1];
            r_pq[1] <= q_s;
            for (int i = 2; i <= 3; i++) r_pq[i] <= r_pq[i-1];
            ra_ll   <= {32'b0, ps[31:0]} * {32'b0, ps[31:0]};
            ra_hl   <= ps[63:32] * ps[31:0];
            r_c2[1] <= c2_full >>> 19;
            for (int i = 2; i <= 3; i++) r_c2[i] <= r_c2[i-1];
            rb_sq   <= ra_ll + {ra_hl[30:0], 33'b0};
            rc_c1   <= c1_full >>> 25;
            rd_p    <= ((r_pq[3] + rc_c1 + r_c2[3]) >>> 8) + (p7 <<< 4);
            r_oside <= r_ps[4];
            priority if (r_ps[4].dz || rd_p[63]) begin
                r_press <= '0;
            end else if (rd_p[62:32] != '0) begin
                r_press <= '1;
            end else begin
                r_press <= rd_p[31:0];
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_temperature_centi = r_oside.centi;
    assign o_fine_temperature  = r_oside.fine;
    assign o_pressure_q24_8    = r_press;
    assign o_divide_by_zero    = r_oside.dz;

`ifndef SYNTHESIS
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divide_by_zero |-> o_pressure_q24_8 == '0)
        else $error("pressure not zero on zero divisor");
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_v[1])
        else $error("accepted item lost at entry");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(r_v) && $stable(r_pv))
        else $error("pipeline moved while output stalled");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");
`endif

endmodule

// File: tb/tb_baro_temp_pressure_compensation.sv
// Testbench for the barometric temperature and pressure compensation block.
`timescale 1ns / 100ps

class compensation_scoreboard;
    logic [47:0] temp_words;
    logic [63:0] press_low;
    logic [63:0] press_mid;
    logic [15:0] press_nine;
    logic [24:0] q_centi[$];
    logic [31:0] q_fine[$];
    logic [31:0] q_press[$];
    logic        q_dz[$];
    int          errors;

    function void clear_coeffs();
        temp_words = '0;
        press_low  = '0;
        press_mid  = '0;
        press_nine = '0;
        errors     = 0;
    endfunction

    function void write_coeff(btpc_pkg::t_cfg_idx idx, logic [63:0] data);
        case (idx)
            btpc_pkg::CFG_TEMP_COEFF: temp_words = data[47:0];
            btpc_pkg::CFG_PRESS_LOW:  press_low  = data;
            btpc_pkg::CFG_PRESS_MID:  press_mid  = data;
            btpc_pkg::CFG_PRESS_NINE: press_nine = data[15:0];
            default: ;
        endcase
    endfunction

    function logic signed [63:0] sx(logic [15:0] w);
        return {{48{w[15]}}, w};
    endfunction

    function void note_reading(logic [19:0] raw_t, logic [19:0] raw_p);
        logic signed [31:0] t1, t2, t3, a, d, b, fine, centi;
        logic signed [63:0] v1, v2, w1, p, ps, c1, c2, num;
        logic [63:0] ua, ub, uq;
        logic [31:0] pr;
        logic dz;
        t1 = {16'd0, temp_words[15:0]};
        t2 = {{16{temp_words[31]}}, temp_words[31:16]};
        t3 = {{16{temp_words[47]}}, temp_words[47:32]};
        a = ((($signed({12'd0, raw_t}) >>> 3) - (t1 <<< 1)) * t2) >>> 11;
        d = ({12'd0, raw_t} >>> 4) - t1;
        b = (((d * d) >>> 12) * t3) >>> 14;
        fine = a + b;
        centi = (fine * 5 + 128) >>> 8;
        v1 = 64'(fine) - 64'sd128000;
        v2 = v1 * v1 * sx(press_mid[31:16]);
        v2 = v2 + ((v1 * sx(press_mid[15:0])) <<< 17);
        v2 = v2 + (sx(press_low[63:48]) <<< 35);
        w1 = ((v1 * v1 * sx(press_low[47:32])) >>> 8) + ((v1 * sx(press_low[31:16])) <<< 12);
        w1 = (((64'sd1 <<< 47) + w1) * $signed({48'd0, press_low[15:0]})) >>> 33;
        pr = '0;
        dz = 1'b0;
        if (w1 == 0) begin
            dz = 1'b1;
        end else begin
            p = 64'sd1048576 - $signed({44'd0, raw_p});
            num = ((p <<< 31) - v2) * 64'sd3125;
            ua = num[63] ? -num : num;
            ub = w1[63] ? -w1 : w1;
            uq = ua / ub;
            p = (num[63] != w1[63]) ? -$signed(uq) : $signed(uq);
            ps = p >>> 13;
            c1 = (sx(press_nine) * ps * ps) >>> 25;
            c2 = (sx(press_mid[63:48]) * p) >>> 19;
            p = ((p + c1 + c2) >>> 8) + (sx(press_mid[47:32]) <<< 4);
            if (p[63]) pr = '0;
            else if (p > 64'sh0_FFFF_FFFF) pr = '1;
            else pr = p[31:0];
        end
        q_centi.push_back(centi[24:0]);
        q_fine.push_back(fine);
        q_press.push_back(pr);
        q_dz.push_back(dz);
    endfunction

    function void check_result(logic [24:0] centi, logic [31:0] fine, logic [31:0] pr,
                               logic dz);
        logic [24:0] e_centi;
        logic [31:0] e_fine, e_press;
        logic e_dz;
        if (q_fine.size() == 0) begin
            $display("%0t: unexpected result", $time);
            errors++;
            return;
        end
        e_centi = q_centi.pop_front();
        e_fine  = q_fine.pop_front();
        e_press = q_press.pop_front();
        e_dz    = q_dz.pop_front();
        if (centi !== e_centi) begin
            $display("%0t: centi exp %h got %h", $time, e_centi, centi);
            errors++;
        end
        if (fine !== e_fine) begin
            $display("%0t: fine exp %h got %h", $time, e_fine, fine);
            errors++;
        end
        if (pr !== e_press) begin
            $display("%0t: pressure exp %h got %h", $time, e_press, pr);
            errors++;
        end
        if (dz !== e_dz) begin
            $display("%0t: dz exp %b got %b", $time, e_dz, dz);
            errors++;
        end
    endfunction

    function int pending();
        return q_fine.size();
    endfunction
endclass

module tb_baro_temp_pressure_compensation;
    import btpc_pkg::*;

    localparam int LATENCY = 82;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [RAW_W-1:0] i_raw_temperature = '0;
    logic [RAW_W-1:0] i_raw_pressure = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [CENTI_W-1:0] o_temperature_centi;
    logic signed [31:0] o_fine_temperature;
    logic [31:0] o_pressure_q24_8;
    logic o_divide_by_zero;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    compensation_scoreboard readings;
    int idle_cycles = 0;
    bit hold_off = 1'b0;
    bit stall_busy = 1'b0;

    baro_temp_pressure_compensation dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall)
            readings.note_reading(i_raw_temperature, i_raw_pressure);
        if (i_rst_n && o_out_valid && !i_out_stall)
            readings.check_result(o_temperature_centi, o_fine_temperature,
                                  o_pressure_q24_8, o_divide_by_zero);
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_off)
            i_out_stall <= 1'b1;
        else if (stall_busy)
            i_out_stall <= ($urandom_range(0, 3) == 0);
        else
            i_out_stall <= 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("baro_temp_pressure_compensation test failed");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        readings.write_coeff(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_reading(logic [19:0] raw_t, logic [19:0] raw_p, bit keep);
        i_in_valid <= 1'b1;
        i_raw_temperature <= raw_t;
        i_raw_pressure <= raw_p;
        do @(posedge i_clk); while (o_in_stall);
        if (!keep)
            i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (readings.pending() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic random_burst(int count);
        int burst;
        int gap;
        int n;
        n = 0;
        while (n < count) begin
            burst = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 12) : 0;
            for (int k = 0; k < burst && n < count; k++) begin
                n++;
                send_reading(20'($urandom_range(0, 20'hFFFFF)),
                             20'($urandom_range(0, 20'hFFFFF)),
                             (k < burst - 1 || gap == 0) && n < count);
            end
            if (gap != 0)
                repeat (gap) @(posedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // typical calibration with random jitter
    function automatic logic [63:0] jitter(logic [63:0] base);
        logic [63:0] r;
        r = base;
        for (int k = 0; k < 4; k++)
            r[k*16 +: 16] = base[k*16 +: 16] + 16'($urandom_range(0, 63)) - 16'd32;
        return r;
    endfunction

    task automatic load_set(int sel);
        case (sel)
            0: begin
                write_reg(CFG_TEMP_COEFF, jitter(64'({16'hFC18, 16'd26435, 16'd27504})));
                write_reg(CFG_PRESS_LOW, jitter({16'd2855, 16'hDE0B, 16'hFFE2, 16'hFF72}) |
                                         64'd0);
                write_reg(CFG_PRESS_LOW, {16'd2855, 16'hD0D8, 16'd3024,
                                          16'(36477 + $urandom_range(0, 99))});
                write_reg(CFG_PRESS_MID, jitter({16'hC3EC, 16'd15500, 16'hFFF9, 16'd140}));
                write_reg(CFG_PRESS_NINE, 64'(16'd6000 + 16'($urandom_range(0, 99))));
            end
            1: begin
                write_reg(CFG_TEMP_COEFF, {$urandom, $urandom});
                write_reg(CFG_PRESS_LOW, {$urandom, $urandom});
                write_reg(CFG_PRESS_MID, {$urandom, $urandom});
                write_reg(CFG_PRESS_NINE, {$urandom, $urandom});
            end
            2: begin
                write_reg(CFG_TEMP_COEFF, '1);
                write_reg(CFG_PRESS_LOW, '1);
                write_reg(CFG_PRESS_MID, '1);
                write_reg(CFG_PRESS_NINE, 64'h7FFF);
            end
            default: begin
                write_reg(CFG_TEMP_COEFF, 64'h8000_8000_0000);
                write_reg(CFG_PRESS_LOW, 64'h8000_8000_8000_FFFF);
                write_reg(CFG_PRESS_MID, 64'h7FFF_8000_7FFF_8000);
                write_reg(CFG_PRESS_NINE, 64'h8000);
            end
        endcase
    endtask

    initial begin
        readings = new();
        readings.clear_coeffs();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero calibration: divisor zero
        send_reading('0, '0, 1'b1);
        send_reading('1, '1, 1'b0);
        drain();
        load_set(0);
        send_reading('0, '0, 1'b1);
        send_reading('1, '1, 1'b1);
        send_reading('0, '1, 1'b1);
        send_reading('1, '0, 1'b1);
        send_reading(20'd519888, 20'd415148, 1'b1);
        send_reading(20'h80000, 20'h80000, 1'b0);
        drain();
        load_set(3);
        send_reading('0, '0, 1'b1);
        send_reading('1, '1, 1'b0);
        drain();
        load_set(2);
        send_reading('0, '0, 1'b1);
        send_reading('1, '1, 1'b0);
        drain();
        // P1 zero with other words set: divisor zero
        write_reg(CFG_PRESS_LOW, 64'h1234_5678_9ABC_0000);
        send_reading(20'd519888, 20'd415148, 1'b0);
        drain();

        load_set(0);
        stall_busy = 1'b1;
        random_burst(300);
        fork
            begin
                hold_off = 1'b1;
                repeat (LATENCY * 3) @(posedge i_clk);
                hold_off = 1'b0;
            end
            random_burst(150);
        join
        drain();
        load_set(1);
        random_burst(150);
        drain();
        load_set(0);
        stall_busy = 1'b0;
        random_burst(150);
        drain();
        load_set(1);
        stall_busy = 1'b1;
        random_burst(100);
        drain();
        load_set(0);
        random_burst(80);
        drain();

        if (readings.errors == 0)
            $display("baro_temp_pressure_compensation test passed");
        else
            $display("baro_temp_pressure_compensation test failed");
        $finish;
    end
endmodule

// File: filelist.f
design/btpc_pkg.sv
design/btpc_div.sv
design/baro_temp_pressure_compensation.sv
tb/tb_baro_temp_pressure_compensation.sv
